// File: hw/rtl/uv_sphere_vertex_generator_top_assert.svh
// Assertion macros used by the checker of the sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVS_ASSERT_IMPLY(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// The consequent must hold one pipeline latency after the antecedent.
`define UVS_ASSERT_DELAY(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ant) |-> ##(uvs_pkg::LATENCY) (con)) else $error(msg);

// The condition must never be seen out of reset.
`define UVS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hw/rtl/uvs_pkg.sv
// Shared types, constants and arithmetic helpers of the sphere vertex generator.
`default_nettype none

package uvs_pkg;

    // Field widths fixed by the request and result formats.
    localparam int INDEX_BITS = 8;
    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int RING_BITS  = 9;
    localparam int MAG_BITS   = 31;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_POLAR_STEP    = 2'd0,
        REG_AZIMUTH_STEP  = 2'd1,
        REG_SPHERE_RADIUS = 2'd2,
        REG_RING_VERTICES = 2'd3
    } reg_index_t;

    // Register values after reset.
    localparam logic [CFG_BITS-1:0]  POLAR_STEP_RST    = 16'd1092;
    localparam logic [CFG_BITS-1:0]  AZIMUTH_STEP_RST  = 16'd2731;
    localparam logic [CFG_BITS-1:0]  SPHERE_RADIUS_RST = 16'd256;
    localparam logic [RING_BITS-1:0] RING_VERTICES_RST = 9'd25;

    // Quarter-wave sine polynomial in Q30, highest order first.
    localparam int HORNER_STEPS = 4;
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
    localparam logic signed [32:0] POLY_COEF [0:HORNER_STEPS] = '{
        33'sd172272,
        -33'sd5026995,
        33'sd85569306,
        -33'sd693598668,
        33'sd1686629713
    };

    // Pipeline depths: index stage, sine-cosine stages, scaling stages.
    localparam int SC_STAGES    = HORNER_STEPS + 2;
    localparam int SCALE_STAGES = 3;
    localparam int LATENCY      = 1 + SC_STAGES + SCALE_STAGES;

    typedef struct packed {
        logic [INDEX_BITS-1:0] layer_index;
        logic [INDEX_BITS-1:0] column_index;
    } vertex_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
        logic                         index_error;
    } vertex_t;

    // Sine and cosine of one angle as magnitude and sign.
    typedef struct packed {
        logic                valid;
        logic                sin_neg;
        logic [MAG_BITS-1:0] sin_mag;
        logic                cos_neg;
        logic [MAG_BITS-1:0] cos_mag;
    } sincos_t;

    // Q30 product with truncation of the magnitude toward zero.
    function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        neg = a[32] ^ b[32];
        ma = a[32] ? 32'(-a) : 32'(a);
        mb = b[32] ? 32'(-b) : 32'(b);
        p = {32'd0, ma} * {32'd0, mb};
        mul_q30 = neg ? -$signed({1'b0, p[61:30]}) : $signed({1'b0, p[61:30]});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/uv_sphere_vertex_generator_top.sv
// Throughput: one request per cycle; busy stays low and the result strobe cannot be held off.
// The pipeline has one index stage, six sine-cosine polynomial stages and three
// scaling stages. Reset clears every valid bit and loads the register defaults.
`default_nettype none

module uv_sphere_vertex_generator_top #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  uvs_pkg::vertex_req_t          vertex_req,
    input  logic                          wr_en,
    input  uvs_pkg::reg_index_t           wr_index,
    input  logic [uvs_pkg::CFG_BITS-1:0]  wr_data,
    output logic                          done,
    output uvs_pkg::vertex_t              vertex
);

    localparam int PROD_BITS = uvs_pkg::INDEX_BITS + uvs_pkg::CFG_BITS;

    logic [uvs_pkg::CFG_BITS-1:0]  polar_step_reg;
    logic [uvs_pkg::CFG_BITS-1:0]  azimuth_step_reg;
    logic [uvs_pkg::CFG_BITS-1:0]  radius_reg;
    logic [uvs_pkg::RING_BITS-1:0] ring_reg;

    logic                          accept;
    logic [uvs_pkg::RING_BITS-1:0] col_ext;
    logic                          out_of_range;
    logic                          closing;
    logic [PROD_BITS-1:0]          pol_full;
    logic [PROD_BITS-1:0]          az_full;

    logic                  s0_valid_reg;
    logic                  s0_err_reg;
    logic [ANGLE_BITS-1:0] pol_reg;
    logic [ANGLE_BITS-1:0] az_reg;
    logic                  err_pipe_reg [0:uvs_pkg::SC_STAGES-1];

    uvs_pkg::sincos_t polar_sc;
    uvs_pkg::sincos_t azimuth_sc;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polar_step_reg   <= uvs_pkg::POLAR_STEP_RST;
            azimuth_step_reg <= uvs_pkg::AZIMUTH_STEP_RST;
            radius_reg       <= uvs_pkg::SPHERE_RADIUS_RST;
            ring_reg         <= uvs_pkg::RING_VERTICES_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                uvs_pkg::REG_POLAR_STEP:    polar_step_reg   <= wr_data;
                uvs_pkg::REG_AZIMUTH_STEP:  azimuth_step_reg <= wr_data;
                uvs_pkg::REG_SPHERE_RADIUS: radius_reg       <= wr_data;
                uvs_pkg::REG_RING_VERTICES: ring_reg         <= wr_data[uvs_pkg::RING_BITS-1:0];
            endcase
        end
    end

    // The pipeline never stalls, so a request is taken every cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Column checks and angle products.
    assign col_ext      = uvs_pkg::RING_BITS'(vertex_req.column_index);
    assign out_of_range = col_ext >= ring_reg;
    assign closing      = (col_ext + uvs_pkg::RING_BITS'(1)) == ring_reg;
    assign pol_full     = PROD_BITS'(vertex_req.layer_index) * PROD_BITS'(polar_step_reg);
    assign az_full      = PROD_BITS'(vertex_req.column_index) * PROD_BITS'(azimuth_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= accept;
    end

    // Index stage, plus the error flag delayed to meet the sine-cosine results.
    always_ff @(posedge clk)
    begin
        pol_reg    <= pol_full[ANGLE_BITS-1:0];
        az_reg     <= closing ? '0 : az_full[ANGLE_BITS-1:0];
        s0_err_reg <= out_of_range;
        err_pipe_reg[0] <= s0_err_reg;
        for (int s = 1; s < uvs_pkg::SC_STAGES; s++)
            err_pipe_reg[s] <= err_pipe_reg[s-1];
    end

    uvs_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_polar (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s0_valid_reg),
        .angle    (pol_reg),
        .result   (polar_sc)
    );

    uvs_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_azimuth (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s0_valid_reg),
        .angle    (az_reg),
        .result   (azimuth_sc)
    );

    uvs_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .polar       (polar_sc),
        .azimuth     (azimuth_sc),
        .index_error (err_pipe_reg[uvs_pkg::SC_STAGES-1]),
        .radius      (radius_reg),
        .done        (done),
        .vertex      (vertex)
    );

endmodule

`default_nettype wire

// File: hw/rtl/uvs_sincos.sv
// Pipelined sine and cosine of one turn-fraction angle.
`default_nettype none

module uvs_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [ANGLE_BITS-1:0]  angle,
    output uvs_pkg::sincos_t       result
);

    localparam int LAST = uvs_pkg::HORNER_STEPS;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-2:0] QUARTER_U = (ANGLE_BITS - 1)'(1) << (ANGLE_BITS - 2);

    logic [LAST:0]     valid_reg;
    logic signed [32:0] t_reg    [0:LAST][0:1];
    logic signed [32:0] t2_reg   [0:LAST][0:1];
    logic signed [32:0] poly_reg [0:LAST][0:1];
    logic               neg_reg  [0:LAST][0:1];

    logic [ANGLE_BITS-1:0] lane_angle [0:1];
    logic [ANGLE_BITS-2:0] lane_u     [0:1];
    logic signed [32:0]    lane_t     [0:1];
    logic signed [32:0]    final_p    [0:1];
    logic [uvs_pkg::MAG_BITS-1:0] final_mag [0:1];

    logic                         out_valid_reg;
    logic                         out_neg_reg [0:1];
    logic [uvs_pkg::MAG_BITS-1:0] out_mag_reg [0:1];

    // Quadrant reduction: lane 0 is the sine, lane 1 the cosine.
    always_comb
    begin
        lane_angle[0] = angle;
        lane_angle[1] = angle + QUARTER_TURN;
        for (int l = 0; l < 2; l++)
        begin
            if (lane_angle[l][ANGLE_BITS-2])
                lane_u[l] = QUARTER_U - (ANGLE_BITS - 1)'(lane_angle[l][ANGLE_BITS-3:0]);
            else
                lane_u[l] = (ANGLE_BITS - 1)'(lane_angle[l][ANGLE_BITS-3:0]);
            lane_t[l] = $signed(33'(lane_u[l]) << (32 - ANGLE_BITS));
        end
    end

    // Last multiply by t and clamp to the unit range.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            final_p[l] = uvs_pkg::mul_q30(poly_reg[LAST][l], t_reg[LAST][l]);
            if (final_p[l] < 33'sd0)
                final_mag[l] = '0;
            else if (final_p[l] > uvs_pkg::ONE_Q30)
                final_mag[l] = uvs_pkg::ONE_Q30[uvs_pkg::MAG_BITS-1:0];
            else
                final_mag[l] = final_p[l][uvs_pkg::MAG_BITS-1:0];
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[LAST-1:0], in_valid};
            out_valid_reg <= valid_reg[LAST];
        end
    end

    // Square of t, then one Horner step per stage.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            t_reg[0][l]    <= lane_t[l];
            t2_reg[0][l]   <= uvs_pkg::mul_q30(lane_t[l], lane_t[l]);
            poly_reg[0][l] <= uvs_pkg::POLY_COEF[0];
            neg_reg[0][l]  <= lane_angle[l][ANGLE_BITS-1];
            for (int s = 1; s <= LAST; s++)
            begin
                poly_reg[s][l] <= uvs_pkg::POLY_COEF[s]
                                  + uvs_pkg::mul_q30(poly_reg[s-1][l], t2_reg[s-1][l]);
                t_reg[s][l]    <= t_reg[s-1][l];
                t2_reg[s][l]   <= t2_reg[s-1][l];
                neg_reg[s][l]  <= neg_reg[s-1][l];
            end
            out_mag_reg[l] <= final_mag[l];
            out_neg_reg[l] <= neg_reg[LAST][l];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.sin_neg = out_neg_reg[0];
    assign result.sin_mag = out_mag_reg[0];
    assign result.cos_neg = out_neg_reg[1];
    assign result.cos_mag = out_mag_reg[1];

endmodule

`default_nettype wire

// File: hw/rtl/uvs_scale.sv
// Radius scaling, rounding and saturation of the vertex coordinates.
`default_nettype none

module uvs_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uvs_pkg::sincos_t              polar,
    input  uvs_pkg::sincos_t              azimuth,
    input  logic                          index_error,
    input  logic [uvs_pkg::CFG_BITS-1:0]  radius,
    output logic                          done,
    output uvs_pkg::vertex_t              vertex
);

    localparam int XY_SHIFT = 45;
    localparam int Z_SHIFT  = 30;
    localparam logic [63:0] COORD_HI = (64'd1 << (uvs_pkg::COORD_BITS - 1)) - 64'd1;
    localparam logic [63:0] COORD_LO_MAG = COORD_HI + 64'd1;

    // Saturate a rounded magnitude with its sign to the coordinate range.
    function automatic logic [uvs_pkg::COORD_BITS-1:0] saturate(input logic neg,
                                                                input logic [63:0] v);
        if (!neg)
            saturate = (v > COORD_HI) ? uvs_pkg::COORD_BITS'(COORD_HI)
                                      : uvs_pkg::COORD_BITS'(v);
        else
            saturate = (v > COORD_LO_MAG) ? uvs_pkg::COORD_BITS'(COORD_LO_MAG)
                                          : uvs_pkg::COORD_BITS'(64'd0 - v);
    endfunction

    logic [46:0] rs_full;
    logic [46:0] z_full;

    logic        g_valid_reg;
    logic        g_err_reg;
    logic [31:0] g_rs_reg;
    logic [46:0] g_zprod_reg;
    logic        g_xneg_reg;
    logic        g_yneg_reg;
    logic        g_zneg_reg;
    logic [uvs_pkg::MAG_BITS-1:0] g_camag_reg;
    logic [uvs_pkg::MAG_BITS-1:0] g_samag_reg;

    logic        h_valid_reg;
    logic        h_err_reg;
    logic [62:0] h_xprod_reg;
    logic [62:0] h_yprod_reg;
    logic [46:0] h_zprod_reg;
    logic        h_xneg_reg;
    logic        h_yneg_reg;
    logic        h_zneg_reg;

    logic [63:0] x_round;
    logic [63:0] y_round;
    logic [63:0] z_round;

    logic             done_reg;
    uvs_pkg::vertex_t vertex_reg;

    // Radius times the polar sine and cosine magnitudes.
    assign rs_full = 47'(radius) * 47'(polar.sin_mag);
    assign z_full  = 47'(radius) * 47'(polar.cos_mag);

    // Round half away from zero on the magnitudes.
    assign x_round = (64'(h_xprod_reg) + (64'd1 << (XY_SHIFT - 1))) >> XY_SHIFT;
    assign y_round = (64'(h_yprod_reg) + (64'd1 << (XY_SHIFT - 1))) >> XY_SHIFT;
    assign z_round = (64'(h_zprod_reg) + (64'd1 << (Z_SHIFT - 1))) >> Z_SHIFT;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            g_valid_reg <= polar.valid & azimuth.valid;
            h_valid_reg <= g_valid_reg;
            done_reg    <= h_valid_reg;
        end
    end

    // Scaling datapath.
    always_ff @(posedge clk)
    begin
        g_err_reg   <= index_error;
        g_rs_reg    <= rs_full[46:15];
        g_zprod_reg <= z_full;
        g_xneg_reg  <= polar.sin_neg ^ azimuth.cos_neg;
        g_yneg_reg  <= polar.sin_neg ^ azimuth.sin_neg;
        g_zneg_reg  <= polar.cos_neg;
        g_camag_reg <= azimuth.cos_mag;
        g_samag_reg <= azimuth.sin_mag;

        h_err_reg   <= g_err_reg;
        h_xprod_reg <= 63'(g_rs_reg) * 63'(g_camag_reg);
        h_yprod_reg <= 63'(g_rs_reg) * 63'(g_samag_reg);
        h_zprod_reg <= g_zprod_reg;
        h_xneg_reg  <= g_xneg_reg;
        h_yneg_reg  <= g_yneg_reg;
        h_zneg_reg  <= g_zneg_reg;

        // A flagged column returns the origin.
        if (h_err_reg)
        begin
            vertex_reg.x_coord <= '0;
            vertex_reg.y_coord <= '0;
            vertex_reg.z_coord <= '0;
        end
        else
        begin
            vertex_reg.x_coord <= $signed(saturate(h_xneg_reg, x_round));
            vertex_reg.y_coord <= $signed(saturate(h_yneg_reg, y_round));
            vertex_reg.z_coord <= $signed(saturate(h_zneg_reg, z_round));
        end
        vertex_reg.index_error <= h_err_reg;
    end

    assign done   = done_reg;
    assign vertex = vertex_reg;

endmodule

`default_nettype wire

// File: hw/rtl/uvs_checker.sv
// Port-level checker of the sphere vertex generator and its bind.
`default_nettype none

`include "uv_sphere_vertex_generator_top_assert.svh"

module uvs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input uvs_pkg::vertex_t vertex
);

    logic req_taken;
    logic at_origin;

    // A request is taken at an edge where start is high and busy is low.
    assign req_taken = start && !busy;
    assign at_origin = (vertex.x_coord == '0) && (vertex.y_coord == '0)
                       && (vertex.z_coord == '0);

    // The block takes a request in every cycle.
    `UVS_ASSERT_NEVER(a_never_busy, busy, "busy raised")

    // Every request yields a result after the pipeline latency.
    `UVS_ASSERT_DELAY(a_result_follows, req_taken, done, "result missing")

    // No result appears without a request that caused it.
    `UVS_ASSERT_IMPLY(a_no_invented, done, $past(req_taken, uvs_pkg::LATENCY), "result invented")

    // A flagged column carries the origin.
    `UVS_ASSERT_IMPLY(a_error_zero, done && vertex.index_error, at_origin, "flagged result not zero")

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .vertex (vertex)
);

`default_nettype wire
